>>> design/bba_pkg.sv
package bba_pkg;
	localparam int POOL_PAGES = 16;
	localparam int HEADER_BYTES = 16;
	localparam int MIN_LEVEL = 4;
	localparam int MAX_LEVEL = 12;
	localparam int GRAN_SHIFT = 4;
	localparam int GRANULES = 4096;
	localparam int GW = 12;
	localparam int NUM_LISTS = MAX_LEVEL - MIN_LEVEL + 1;
	localparam int LW = $clog2(NUM_LISTS);
	localparam int ADDR_PAGES = 65536 >> MAX_LEVEL;
	localparam int PAGE_LIMIT = (POOL_PAGES < ADDR_PAGES) ? POOL_PAGES : ADDR_PAGES;
	localparam int PW = $clog2(PAGE_LIMIT + 1);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [15:0] request_size;
		logic [15:0] free_address;
	} req_t;

	typedef struct packed {
		logic [15:0] result_address;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic       we;
		logic [GW-1:0] addr;
		logic [3:0] level;
		logic       free;
	} meta_wr_t;
endpackage

>>> design/bba_meta_ram.sv
module bba_meta_ram (
	input  logic              clk,
	input  bba_pkg::meta_wr_t wr,
	input  logic [11:0]       raddr,
	output logic [3:0]        rlevel,
	output logic              rfree
);
	import bba_pkg::*;

	logic [4:0] mem [GRANULES];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= {wr.level, wr.free};
		end
		{rlevel, rfree} <= mem[raddr];
	end
endmodule

>>> design/buddy_block_allocator.sv
// Binary buddy allocator over a pool of 4 KB pages, blocks of 16 B to 4 KB.
// in_valid/in_ready carry one request word: opcode (allocate or free),
// request_size and free_address. out_valid/out_ready carry one result word:
// result_address and status. Every request gives exactly one result.
// One request at a time: in_ready is high only when the sequencer is idle
// and the output register is empty or being taken. An allocate first rounds
// the size up by doublings from 16 B, then probes the free lists upward from
// that level, takes a new page when none holds a block, pops the head of the
// list it found (a link read, then a head update) and splits down to size;
// a request that is too large or finds the pool exhausted ends at the size or
// probe step. A free reads and checks the block's metadata, then per level
// reads the buddy and merges while it is free at the same level; a buddy at
// its list head is unlinked by reading its link, one further down by walking
// the list. All block metadata lives in memories with registered read and a
// separate write port. Reset clears the free lists and the page count;
// the metadata memory is not cleared and is written before use. A stalled
// receiver holds the result word; the next request waits until it is taken.
module buddy_block_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bba_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output bba_pkg::rsp_t out_data
);
	import bba_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SIZE = 4'd1;
	localparam logic [3:0] S_PROBE = 4'd2;
	localparam logic [3:0] S_POPRD = 4'd3;
	localparam logic [3:0] S_POPWT = 4'd4;
	localparam logic [3:0] S_SPLIT = 4'd5;
	localparam logic [3:0] S_FRD = 4'd6;
	localparam logic [3:0] S_FCHK = 4'd7;
	localparam logic [3:0] S_BRD = 4'd8;
	localparam logic [3:0] S_BCHK = 4'd9;
	localparam logic [3:0] S_WALK = 4'd10;
	localparam logic [3:0] S_WCHK = 4'd11;
	localparam logic [3:0] S_MERGE = 4'd12;
	localparam logic [3:0] S_FIN = 4'd13;
	localparam logic [3:0] S_RNXT = 4'd14;

	logic [3:0] state_q;
	logic [GW-1:0] head_q [NUM_LISTS];
	logic [GW-1:0] tail_q [NUM_LISTS];
	logic [NUM_LISTS-1:0] ne_q;
	logic [PW-1:0] pages_q;
	logic [GW-1:0] nxt_mem [GRANULES];
	logic [GW-1:0] nxt_rd_q;
	logic [GW-1:0] nxt_ra;
	logic [GW-1:0] nxt_wa;
	logic [GW-1:0] nxt_wd;
	logic nxt_we;

	rsp_t rsp_q;
	logic ov_q;
	logic [3:0] lv_q;
	logic [3:0] k_q;
	logic [GW-1:0] b_q;
	logic [GW-1:0] bud_q;
	logic [GW-1:0] cur_q;
	logic [12:0] walk_q;
	logic [16:0] size_q;
	logic [4:0] cnt_q;

	meta_wr_t mw;
	logic [GW-1:0] mra;
	logic [3:0] mlevel;
	logic mfree;

	bba_meta_ram u_meta (
		.clk(clk), .wr(mw), .raddr(mra), .rlevel(mlevel), .rfree(mfree)
	);

	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_wa] <= nxt_wd;
		end
		nxt_rd_q <= nxt_mem[nxt_ra];
	end

	function automatic logic [LW-1:0] li(input logic [3:0] l);
		return LW'(l - 4'(MIN_LEVEL));
	endfunction

	logic [GW-1:0] bud_c;
	logic [GW-1:0] right_c;
	logic [3:0] half_c;
	assign bud_c = b_q ^ (GW'(1) << (lv_q - 4'(GRAN_SHIFT)));
	assign half_c = k_q - 4'd1;
	assign right_c = b_q + (GW'(1) << (half_c - 4'(GRAN_SHIFT)));

	assign in_ready = (state_q == S_IDLE) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign out_data = rsp_q;

	always_comb begin
		mw = '0;
		mra = b_q;
		nxt_we = 1'b0;
		nxt_wa = cur_q;
		nxt_wd = nxt_rd_q;
		nxt_ra = cur_q;
		unique case (state_q)
			S_POPRD: nxt_ra = head_q[li(k_q)];
			S_SPLIT: begin
				if (k_q > lv_q) begin
					mw = '{we: 1'b1, addr: right_c, level: half_c, free: 1'b1};
					if (ne_q[li(half_c)]) begin
						nxt_we = 1'b1;
						nxt_wa = tail_q[li(half_c)];
						nxt_wd = right_c;
					end
				end else begin
					mw = '{we: 1'b1, addr: b_q, level: lv_q, free: 1'b0};
				end
			end
			S_BRD: mra = bud_c;
			S_WALK: nxt_ra = cur_q;
			S_RNXT: nxt_ra = bud_q;
			S_WCHK: begin
				if (cnt_q == 5'd1) begin
					nxt_we = 1'b1;
					nxt_wa = cur_q;
					nxt_wd = nxt_rd_q;
				end
			end
			S_MERGE: begin
				mw = '{we: 1'b1, addr: (b_q < bud_q) ? bud_q : b_q, level: lv_q, free: 1'b1};
			end
			S_FIN: begin
				mw = '{we: 1'b1, addr: b_q, level: lv_q, free: 1'b1};
				if (ne_q[li(lv_q)]) begin
					nxt_we = 1'b1;
					nxt_wa = tail_q[li(lv_q)];
					nxt_wd = b_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			ne_q <= '0;
			pages_q <= '0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						size_q <= {1'b0, in_data.request_size} + 17'(HEADER_BYTES);
						b_q <= GW'((in_data.free_address - 16'(HEADER_BYTES)) >> GRAN_SHIFT);
						lv_q <= 4'(MIN_LEVEL);
						state_q <= (in_data.opcode == OP_FREE) ? S_FRD : S_SIZE;
					end
				end
				S_SIZE: begin
					if (size_q > 17'(1 << MAX_LEVEL)) begin
						rsp_q <= '{result_address: '0, status: ST_TOO_LARGE};
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end else if ((17'd1 << lv_q) < size_q) begin
						lv_q <= lv_q + 4'd1;
					end else begin
						k_q <= lv_q;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (ne_q[li(k_q)]) begin
						b_q <= head_q[li(k_q)];
						state_q <= S_POPRD;
					end else if (k_q != 4'(MAX_LEVEL)) begin
						k_q <= k_q + 4'd1;
					end else if (32'(pages_q) >= PAGE_LIMIT) begin
						rsp_q <= '{result_address: '0, status: ST_EXHAUSTED};
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						b_q <= GW'((32'(pages_q) << MAX_LEVEL) >> GRAN_SHIFT);
						pages_q <= pages_q + PW'(1);
						state_q <= S_SPLIT;
					end
				end
				S_POPRD: state_q <= S_POPWT;
				S_POPWT: begin
					if (head_q[li(k_q)] == tail_q[li(k_q)]) begin
						ne_q[li(k_q)] <= 1'b0;
					end else begin
						head_q[li(k_q)] <= nxt_rd_q;
					end
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					if (k_q > lv_q) begin
						if (!ne_q[li(half_c)]) begin
							head_q[li(half_c)] <= right_c;
							ne_q[li(half_c)] <= 1'b1;
						end
						tail_q[li(half_c)] <= right_c;
						k_q <= half_c;
					end else begin
						rsp_q <= '{result_address: 16'({b_q, 4'b0}) + 16'(HEADER_BYTES),
							status: ST_DONE};
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (mlevel < 4'(MIN_LEVEL) || mlevel > 4'(MAX_LEVEL) || mfree) begin
						rsp_q <= '0;
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lv_q <= mlevel;
						state_q <= (mlevel == 4'(MAX_LEVEL)) ? S_FIN : S_BRD;
					end
				end
				S_BRD: begin
					bud_q <= bud_c;
					state_q <= S_BCHK;
				end
				S_BCHK: begin
					if (mlevel != lv_q || !mfree) begin
						state_q <= S_FIN;
					end else if (!ne_q[li(lv_q)]) begin
						state_q <= S_MERGE;
					end else if (head_q[li(lv_q)] == bud_q) begin
						if (head_q[li(lv_q)] == tail_q[li(lv_q)]) begin
							ne_q[li(lv_q)] <= 1'b0;
							state_q <= S_MERGE;
						end else begin
							cur_q <= bud_q;
							cnt_q <= 5'd0;
							state_q <= S_RNXT;
						end
					end else begin
						cur_q <= head_q[li(lv_q)];
						walk_q <= '0;
						cnt_q <= 5'd0;
						state_q <= S_WALK;
					end
				end
				S_RNXT: begin
					if (cnt_q == 5'd0) begin
						cnt_q <= 5'd2;
					end
					state_q <= S_WCHK;
				end
				S_WALK: begin
					if (cur_q == tail_q[li(lv_q)] || walk_q == 13'(GRANULES)) begin
						state_q <= S_MERGE;
					end else begin
						state_q <= S_WCHK;
					end
				end
				S_WCHK: begin
					if (cnt_q == 5'd2) begin
						head_q[li(lv_q)] <= nxt_rd_q;
						state_q <= S_MERGE;
					end else if (cnt_q == 5'd1) begin
						if (tail_q[li(lv_q)] == bud_q) begin
							tail_q[li(lv_q)] <= cur_q;
						end
						state_q <= S_MERGE;
					end else if (nxt_rd_q == bud_q) begin
						cnt_q <= 5'd1;
						state_q <= S_RNXT;
					end else begin
						cur_q <= nxt_rd_q;
						walk_q <= walk_q + 13'd1;
						state_q <= S_WALK;
					end
				end
				S_MERGE: begin
					b_q <= (b_q < bud_q) ? b_q : bud_q;
					lv_q <= lv_q + 4'd1;
					state_q <= (lv_q + 4'd1 == 4'(MAX_LEVEL)) ? S_FIN : S_BRD;
				end
				S_FIN: begin
					if (!ne_q[li(lv_q)]) begin
						head_q[li(lv_q)] <= b_q;
						ne_q[li(lv_q)] <= 1'b1;
					end
					tail_q[li(lv_q)] <= b_q;
					rsp_q <= '0;
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_busy_not_ready;
		@(posedge clk) disable iff (!arst_n) (state_q != S_IDLE) |-> !in_ready;
	endproperty
	a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result word dropped");

	a_pages: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pages_q) <= PAGE_LIMIT) else $error("page count overrun");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("early result");
endmodule
